// File: rtl/assert_macros.svh
// Assertion helpers used by the keyword spotter back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at each rising clock edge while reset is released.
`define KWS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyword spotter assertion failed");

// Checks a property at every rising clock edge, reset included.
`define KWS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("keyword spotter assertion failed");

`endif

// File: rtl/kws_pkg.sv
package kws_pkg;

    localparam int DEF_DICT_WORDS = 16;
    localparam int DEF_WORD_LEN   = 16;
    localparam int DEF_LINE_LEN   = 1024;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_LINE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam int COLON_MIN  = 9;
    localparam int NAME_START = 10;
    localparam int NAME_W     = 10;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LINE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic              matched;
        logic              colon_found;
        logic [NAME_W-1:0] name_length;
    } res_t;

endpackage

// File: rtl/chat_line_keyword_spotter_core.sv
// Chat line keyword spotter.
// Input channel: push/full queue interface carrying action, data_byte and last.
// Action 0 loads one dictionary byte (last closes the word), action 2 clears
// the dictionary, and action 1 streams a chat line one byte per transfer.
// Action 3 is discarded. A line byte with last set ends the line and yields
// one result: matched, colon_found and name_length.
// Result channel: empty/pop queue interface; the oldest result is shown while
// empty is low and leaves on a pop transfer.
// Throughput is one byte per cycle unless full holds the input: all stored
// words are compared in parallel against the dictionary row for the current
// token position, fetched the cycle before from a row-wide memory. The line's
// last byte is first written into the command queue; the back end writes the
// result into its result queue when it takes that byte, which a full result
// queue delays. Two-entry queues on both sides let the front keep accepting
// while a finished result waits, so a stalled receiver only stops input once
// both queues fill. Reset empties both queues, clears the dictionary and
// restarts line parsing; no clearing pass is needed.
module chat_line_keyword_spotter_core
    import kws_pkg::*;
#(
    parameter int DICT_WORDS = DEF_DICT_WORDS,
    parameter int WORD_LEN   = DEF_WORD_LEN,
    parameter int LINE_LEN   = DEF_LINE_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        action,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output logic              empty,
    input  logic              pop,
    output logic              matched,
    output logic              colon_found,
    output logic [NAME_W-1:0] name_length
);

    // Classified command queue between the front and back ends.
    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;
    res_t res;

    kws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .data_byte (data_byte),
        .last      (last),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    kws_back #(
        .DICT_WORDS (DICT_WORDS),
        .WORD_LEN   (WORD_LEN),
        .LINE_LEN   (LINE_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    // Result fields come straight from the head of the result queue.
    assign matched     = res.matched;
    assign colon_found = res.colon_found;
    assign name_length = res.name_length;

endmodule

// File: rtl/kws_front.sv
module kws_front
    import kws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] action,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_take
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       known;
    logic       wr_en;
    logic       rd_en;
    cmd_t       in_cmd;

    // Unknown actions are dropped here and never reach the back end.
    always_comb
    begin
        known       = 1'b1;
        in_cmd.data = data_byte;
        in_cmd.last = last;
        case (action)
            ACT_LOAD:  in_cmd.op = OP_LOAD;
            ACT_LINE:  in_cmd.op = OP_LINE;
            ACT_CLEAR: in_cmd.op = OP_CLEAR;
            default:
            begin
                in_cmd.op = OP_CLEAR;
                known     = 1'b0;
            end
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign wr_en     = push && !full && known;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign rd_en     = cmd_valid && cmd_take;
    assign cmd       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

// File: rtl/kws_back.sv
`include "assert_macros.svh"

module kws_back
    import kws_pkg::*;
#(
    parameter int DICT_WORDS = DEF_DICT_WORDS,
    parameter int WORD_LEN   = DEF_WORD_LEN,
    parameter int LINE_LEN   = DEF_LINE_LEN
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic empty,
    input  logic pop,
    output res_t res
);

    localparam int CW  = $clog2(DICT_WORDS + 1);
    localparam int WW  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int TPW = $clog2(WORD_LEN + 1);
    localparam int AW  = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
    localparam int LPW = $clog2(LINE_LEN);
    localparam int NLW = (LPW > NAME_W) ? LPW : NAME_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_MESSAGE
    } phase_t;

    // Dictionary: one row per character position, one byte lane per word.
    logic [DICT_WORDS*8-1:0] mem [WORD_LEN];
    logic [DICT_WORDS*8-1:0] rd_reg;
    logic [DICT_WORDS*8-1:0] fwd_mask;
    logic [DICT_WORDS*8-1:0] fwd_data;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;

    logic [TPW-1:0]  len_reg [DICT_WORDS];
    logic [TPW-1:0]  len_next [DICT_WORDS];
    logic [DICT_WORDS-1:0] tl_reg, tl_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [TPW-1:0]  lp_reg, lp_next;
    logic [LPW-1:0]  pos_reg, pos_next;
    logic [LPW-1:0]  colon_reg, colon_next;
    phase_t          phase_reg, phase_next;
    logic [DICT_WORDS-1:0] cand_reg, cand_next;
    logic [TPW-1:0]  tp_reg, tp_next;
    logic            ovf_reg, ovf_next;
    logic            match_reg, match_next;

    res_t       rq_reg [2];
    logic       rq_wr_reg, rq_rd_reg;
    logic [1:0] rq_cnt_reg;
    logic       rq_push, rq_pop;
    res_t       new_res;

    logic [DICT_WORDS-1:0] hit_vec;
    logic                  tok_hit;
    logic [WW-1:0]         wcol;
    logic [NLW-1:0]        name_len;

    assign rq_pop   = pop && !empty;
    assign cmd_take = cmd_valid && (rq_cnt_reg != 2'd2 || rq_pop);
    assign wcol     = count_reg[WW-1:0];
    assign name_len = NLW'(colon_reg) - NLW'(NAME_START);

    always_comb
    begin
        for (int i = 0; i < DICT_WORDS; i++)
        begin
            hit_vec[i] = (CW'(i) < count_reg) && cand_reg[i] && !tl_reg[i]
                         && (len_reg[i] == tp_reg);
        end
        tok_hit = (tp_reg != '0) && !ovf_reg && (|hit_vec);
    end

    always_comb
    begin
        len_next   = len_reg;
        tl_next    = tl_reg;
        count_next = count_reg;
        lp_next    = lp_reg;
        pos_next   = pos_reg;
        colon_next = colon_reg;
        phase_next = phase_reg;
        cand_next  = cand_reg;
        tp_next    = tp_reg;
        ovf_next   = ovf_reg;
        match_next = match_reg;
        we         = 1'b0;
        waddr      = lp_reg[AW-1:0];
        rq_push    = 1'b0;
        new_res    = '0;
        if (cmd_take)
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    if (count_reg < CW'(DICT_WORDS))
                    begin
                        if (lp_reg < TPW'(WORD_LEN))
                        begin
                            we             = 1'b1;
                            lp_next        = lp_reg + 1'b1;
                            len_next[wcol] = lp_reg + 1'b1;
                        end
                        else
                        begin
                            tl_next[wcol] = 1'b1;
                        end
                        if (cmd.last)
                        begin
                            count_next = count_reg + 1'b1;
                            lp_next    = '0;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < DICT_WORDS; i++)
                    begin
                        len_next[i] = '0;
                    end
                    tl_next    = '0;
                    count_next = '0;
                    lp_next    = '0;
                end
                OP_LINE:
                begin
                    if (!cmd.last)
                    begin
                        if (pos_reg < LPW'(LINE_LEN - 1))
                        begin
                            pos_next = pos_reg + 1'b1;
                            case (phase_reg)
                                PH_HEADER:
                                begin
                                    if (pos_reg >= LPW'(COLON_MIN) && cmd.data == CHAR_COLON)
                                    begin
                                        colon_next = pos_reg;
                                        phase_next = PH_SKIP;
                                    end
                                end
                                PH_SKIP:
                                begin
                                    phase_next = PH_MESSAGE;
                                end
                                default:
                                begin
                                    if (cmd.data == CHAR_SPACE)
                                    begin
                                        if (tok_hit)
                                        begin
                                            match_next = 1'b1;
                                        end
                                        cand_next = '1;
                                        tp_next   = '0;
                                        ovf_next  = 1'b0;
                                    end
                                    else if (!ovf_reg)
                                    begin
                                        if (tp_reg >= TPW'(WORD_LEN))
                                        begin
                                            ovf_next = 1'b1;
                                        end
                                        else
                                        begin
                                            for (int i = 0; i < DICT_WORDS; i++)
                                            begin
                                                cand_next[i] = cand_reg[i]
                                                    && (tp_reg < len_reg[i])
                                                    && (rd_reg[i*8 +: 8] == cmd.data);
                                            end
                                            tp_next = tp_reg + 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        rq_push             = 1'b1;
                        new_res.colon_found = (phase_reg != PH_HEADER);
                        new_res.matched     = (phase_reg != PH_HEADER) && (match_reg
                            || (phase_reg == PH_MESSAGE && tok_hit));
                        if (phase_reg != PH_HEADER && colon_reg >= LPW'(NAME_START))
                        begin
                            new_res.name_length = name_len[NAME_W-1:0];
                        end
                        pos_next   = '0;
                        colon_next = '0;
                        phase_next = PH_HEADER;
                        match_next = 1'b0;
                        cand_next  = '1;
                        tp_next    = '0;
                        ovf_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        raddr = (tp_next < TPW'(WORD_LEN)) ? tp_next[AW-1:0] : '0;
    end

    // Byte lane that a same-cycle write to the fetched row must replace.
    always_comb
    begin
        for (int i = 0; i < DICT_WORDS; i++)
        begin
            fwd_mask[i*8 +: 8] = (we && waddr == raddr && wcol == WW'(i)) ? 8'hFF : 8'h00;
            fwd_data[i*8 +: 8] = cmd.data;
        end
    end

    // The row for the next token character is fetched in the cycle before it is used;
    // a write to that row in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wcol*8 +: 8] <= cmd.data;
        end
        rd_reg <= (mem[raddr] & ~fwd_mask) | (fwd_data & fwd_mask);
        if (rq_push)
        begin
            rq_reg[rq_wr_reg] <= new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DICT_WORDS; i++)
            begin
                len_reg[i] <= '0;
            end
            tl_reg     <= '0;
            count_reg  <= '0;
            lp_reg     <= '0;
            pos_reg    <= '0;
            colon_reg  <= '0;
            phase_reg  <= PH_HEADER;
            cand_reg   <= '1;
            tp_reg     <= '0;
            ovf_reg    <= 1'b0;
            match_reg  <= 1'b0;
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            len_reg    <= len_next;
            tl_reg     <= tl_next;
            count_reg  <= count_next;
            lp_reg     <= lp_next;
            pos_reg    <= pos_next;
            colon_reg  <= colon_next;
            phase_reg  <= phase_next;
            cand_reg   <= cand_next;
            tp_reg     <= tp_next;
            ovf_reg    <= ovf_next;
            match_reg  <= match_next;
            if (rq_push)
            begin
                rq_wr_reg <= !rq_wr_reg;
            end
            if (rq_pop)
            begin
                rq_rd_reg <= !rq_rd_reg;
            end
            rq_cnt_reg <= rq_cnt_reg + 2'(rq_push) - 2'(rq_pop);
        end
    end

    assign empty = (rq_cnt_reg == 2'd0);
    assign res   = rq_reg[rq_rd_reg];

    `KWS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DICT_WORDS))
    `KWS_ASSERT(a_token_bound, clk, rst_n, tp_reg <= TPW'(WORD_LEN))
    `KWS_ASSERT(a_header_no_colon, clk, rst_n, phase_reg == PH_HEADER |-> colon_reg == '0)
    `KWS_ASSERT_ALWAYS(a_result_queue_bound, clk, rq_cnt_reg <= 2'd2)

endmodule

// File: tb/chat_line_keyword_spotter_core_test.sv
`timescale 1ns / 1ps

module chat_line_keyword_spotter_core_test;
    import kws_pkg::*;

    localparam int N_WORDS    = DEF_DICT_WORDS;
    localparam int MAX_WORD   = DEF_WORD_LEN;
    localparam int MAX_LINE   = DEF_LINE_LEN;
    localparam int STALL_MAX  = 2000;
    localparam int IDLE_FLUSH = 8;

    // Phases of the line parser: sender name, the byte after the colon, and
    // the message itself.
    typedef enum logic [1:0] {
        PH_NAME,
        PH_GAP,
        PH_TEXT
    } parse_phase_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [1:0]        action;
    logic [7:0]        data_byte;
    logic              last;
    logic              empty;
    logic              pop;
    logic              matched;
    logic              colon_found;
    logic [NAME_W-1:0] name_length;

    chat_line_keyword_spotter_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .data_byte   (data_byte),
        .last        (last),
        .empty       (empty),
        .pop         (pop),
        .matched     (matched),
        .colon_found (colon_found),
        .name_length (name_length)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow copy of the spotter state, used to predict each line verdict.
    logic [7:0]          shadow_chars [N_WORDS][MAX_WORD];
    int unsigned         shadow_len [N_WORDS];
    bit                  shadow_long [N_WORDS];
    int unsigned         shadow_count;
    int unsigned         shadow_load_pos;
    int unsigned         line_pos;
    int unsigned         colon_pos;
    parse_phase_t        phase;
    bit                  alive [N_WORDS];
    int unsigned         tok_pos;
    bit                  tok_over;
    bit                  hit_seen;

    res_t                verdict_queue [$];
    int                  error_count;
    int                  quiet_cycles;
    bit                  calm;      // When set, neither side idles.

    // Words currently in the dictionary, mirrored so that stimulus can build
    // lines that actually hit.
    string               known_words [$];

    function automatic void reset_token();
        for (int i = 0; i < N_WORDS; i++)
        begin
            alive[i] = 1'b1;
        end
        tok_pos  = 0;
        tok_over = 1'b0;
    endfunction

    function automatic void close_token();
        if (tok_pos != 0 && !tok_over)
        begin
            for (int i = 0; i < N_WORDS; i++)
            begin
                if (i < shadow_count && alive[i] && !shadow_long[i] && shadow_len[i] == tok_pos)
                begin
                    hit_seen = 1'b1;
                end
            end
        end
        reset_token();
    endfunction

    function automatic void reset_line();
        line_pos  = 0;
        colon_pos = 0;
        phase     = PH_NAME;
        hit_seen  = 1'b0;
        reset_token();
    endfunction

    function automatic void wipe_dictionary();
        for (int i = 0; i < N_WORDS; i++)
        begin
            shadow_len[i]  = 0;
            shadow_long[i] = 1'b0;
        end
        shadow_count    = 0;
        shadow_load_pos = 0;
    endfunction

    // Advances the shadow state by one accepted byte and queues the verdict
    // that a line end produces.
    function automatic void spot_predict(logic [1:0] act, logic [7:0] b, logic fin);
        res_t        verdict;
        bit          found;
        int unsigned idx;
        if (act == ACT_LOAD)
        begin
            if (shadow_count >= N_WORDS)
            begin
                return;
            end
            if (shadow_load_pos < MAX_WORD)
            begin
                shadow_chars[shadow_count][shadow_load_pos] = b;
                shadow_load_pos++;
                shadow_len[shadow_count] = shadow_load_pos;
            end
            else
            begin
                shadow_long[shadow_count] = 1'b1;
            end
            if (fin)
            begin
                shadow_count++;
                shadow_load_pos = 0;
            end
            return;
        end
        if (act == ACT_CLEAR)
        begin
            wipe_dictionary();
            return;
        end
        if (act != ACT_LINE)
        begin
            return;
        end
        if (!fin)
        begin
            if (line_pos < MAX_LINE - 1)
            begin
                idx = line_pos;
                if (phase == PH_NAME)
                begin
                    if (idx >= COLON_MIN && b == CHAR_COLON)
                    begin
                        colon_pos = idx;
                        phase     = PH_GAP;
                    end
                end
                else if (phase == PH_GAP)
                begin
                    phase = PH_TEXT;
                end
                else if (b == CHAR_SPACE)
                begin
                    close_token();
                end
                else if (!tok_over)
                begin
                    if (tok_pos >= MAX_WORD)
                    begin
                        tok_over = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < N_WORDS; i++)
                        begin
                            alive[i] = alive[i] && tok_pos < shadow_len[i]
                                       && shadow_chars[i][tok_pos] == b;
                        end
                        tok_pos++;
                    end
                end
                line_pos++;
            end
            return;
        end
        if (phase == PH_TEXT)
        begin
            close_token();
        end
        found                = phase != PH_NAME;
        verdict.matched      = found && hit_seen;
        verdict.colon_found  = found;
        verdict.name_length  = (found && colon_pos >= NAME_START)
                               ? NAME_W'(colon_pos - NAME_START) : '0;
        verdict_queue.push_back(verdict);
        reset_line();
    endfunction

    // Sends one byte, with an occasional random gap before it, and waits
    // until the transfer has happened.
    task automatic send_byte(logic [1:0] act, logic [7:0] b, logic fin);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        push      <= 1'b1;
        action    <= act;
        data_byte <= b;
        last      <= fin;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        spot_predict(act, b, fin);
    endtask

    function automatic logic [7:0] random_letter();
        return 8'(8'h61 + $urandom_range(0, 5));
    endfunction

    // Loads a word into the dictionary; words longer than the slot are cut and never match.
    task automatic load_word(string w);
        for (int i = 0; i < w.len(); i++)
        begin
            send_byte(ACT_LOAD, w[i], i == w.len() - 1);
        end
        if (known_words.size() < N_WORDS)
        begin
            known_words.push_back(w);
        end
    endtask

    task automatic clear_words();
        send_byte(ACT_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)));
        known_words.delete();
    endtask

    // Streams a line; the trailing byte is the one that the block drops.
    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(ACT_LINE, s[i], 1'b0);
        end
        send_byte(ACT_LINE, 8'($urandom), 1'b1);
    endtask

    function automatic string random_word(int unsigned len);
        string w;
        w = "";
        for (int i = 0; i < len; i++)
        begin
            w = {w, string'(random_letter())};
        end
        return w;
    endfunction

    // Builds a line with a name of random length and a message made of
    // known words, random words and runs of spaces.
    function automatic string random_line();
        string s;
        int    n;
        s = {random_word($urandom_range(0, 9)), random_word($urandom_range(0, 3))};
        while (s.len() < 9)
        begin
            s = {s, "x"};
        end
        s = {s, random_word($urandom_range(0, 6))};
        if ($urandom_range(0, 9) != 0)
        begin
            s = {s, ": "};
        end
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
        begin
            if (known_words.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                s = {s, known_words[$urandom_range(0, known_words.size() - 1)]};
            end
            else
            begin
                s = {s, random_word($urandom_range(1, 5))};
            end
            s = {s, $urandom_range(0, 3) == 0 ? "  " : " "};
        end
        return s;
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (verdict_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_FLUSH) @(posedge clk);
    endtask

    // Result side: pops with random stalls and compares every transfer.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $error("unexpected result transfer");
                    error_count++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (matched !== want.matched)
                    begin
                        $error("matched: expected %0d, actual %0d", want.matched, matched);
                        error_count++;
                    end
                    if (colon_found !== want.colon_found)
                    begin
                        $error("colon_found: expected %0d, actual %0d",
                               want.colon_found, colon_found);
                        error_count++;
                    end
                    if (name_length !== want.name_length)
                    begin
                        $error("name_length: expected %0d, actual %0d",
                               want.name_length, name_length);
                        error_count++;
                    end
                end
            end
        end
    end

    int stall_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= stall_left == 0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 14);
            pop        <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Watchdog: a long stretch with no transfer on either side is a hang.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > STALL_MAX)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_header_cases();
        load_word("hello");
        load_word("a");
        send_line("abcdefghi: hello");
        send_line("abcdefghij:  a ");
        send_line("0123456789abc: x hello");
        send_line("no colon hello");
        send_line(": early colon a :");
        send_line("");
        send_byte(ACT_LINE, 8'hFF, 1'b1);
    endtask

    task automatic test_dictionary_limits();
        string big;
        clear_words();
        big = random_word(MAX_WORD + 3);
        load_word(big);
        load_word(random_word(MAX_WORD));
        send_line({"nameisten:  ", big.substr(0, MAX_WORD - 1), " ", known_words[1]});
        send_line({"nameisten: ", known_words[1], "q"});
        for (int i = 0; i < N_WORDS; i++)
        begin
            load_word("zz");
        end
        send_line("nameisten: zz");
        send_byte(2'd3, 8'h00, 1'b1);
        send_byte(2'd3, 8'hFF, 1'b0);
        clear_words();
        send_line("nameisten: zz");
        load_word({8'h00, 8'hFF, 8'h20});
        send_line({"nameisten: ", 8'h00, 8'hFF});
    endtask

    // A long name puts the colon close to the line limit; the last token is
    // cut at the limit and the bytes after it are ignored.
    task automatic test_long_line();
        string s;
        load_word("end");
        s = "";
        while (s.len() < MAX_LINE - 8)
        begin
            s = {s, "n"};
        end
        send_line({s, ": ab end end"});
    endtask

    // Words change in the middle of a line: a word completed mid-line can
    // match later tokens.
    task automatic test_midline_change();
        clear_words();
        send_byte(ACT_LINE, "q", 1'b0);
        for (int i = 0; i < 10; i++)
        begin
            send_byte(ACT_LINE, i == 9 ? CHAR_COLON : "n", 1'b0);
        end
        send_byte(ACT_LINE, CHAR_SPACE, 1'b0);
        load_word("hi");
        send_line("hi");
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 560;)
        begin
            int r;
            string s;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                clear_words();
                n++;
            end
            else if (r < 14)
            begin
                s = random_word($urandom_range(1, 6));
                if ($urandom_range(0, 15) == 0)
                begin
                    s = random_word($urandom_range(MAX_WORD - 1, MAX_WORD + 2));
                end
                load_word(s);
                n += s.len();
            end
            else if (r < 17)
            begin
                send_byte(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
                n++;
            end
            else
            begin
                s = random_line();
                send_line(s);
                n += s.len() + 1;
            end
            if (n > 430)
            begin
                calm = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        action       = ACT_LINE;
        data_byte    = 8'h00;
        last         = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        wipe_dictionary();
        reset_line();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_cases();
        test_dictionary_limits();
        wait_drained();
        test_long_line();
        test_midline_change();
        test_random_traffic();
        wait_drained();
        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
